FILE: design/tristate_remote_code_decoder_unit_defines.svh
// Assertion macros used by the top-level RTL file of the decoder.
`ifndef TRISTATE_REMOTE_CODE_DECODER_UNIT_DEFINES_SVH
`define TRISTATE_REMOTE_CODE_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TRCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TRCD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TRCD_ASSERT(lbl, prop, msg)
`define TRCD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: design/trcd_pkg.sv
package trcd_pkg;

  localparam int unsigned LEN_W    = 8;
  localparam int unsigned CODE_W   = 20;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIGITS_DEF = 12;

  localparam logic [CFG_W-1:0] SHORT_MIN_RST = 8'd5;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST = 8'd15;
  localparam logic [CFG_W-1:0] LONG_MIN_RST  = 8'd20;
  localparam logic [CFG_W-1:0] LONG_MAX_RST  = 8'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MIN = 2'd0,
    REG_SHORT_MAX = 2'd1,
    REG_LONG_MIN  = 2'd2,
    REG_LONG_MAX  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIG_ZERO = 2'd0,
    DIG_ONE  = 2'd1,
    DIG_TWO  = 2'd2,
    DIG_BAD  = 2'd3
  } digit_e;

  typedef struct packed {
    logic [CFG_W-1:0] short_min;
    logic [CFG_W-1:0] short_max;
    logic [CFG_W-1:0] long_min;
    logic [CFG_W-1:0] long_max;
  } cfg_t;

  typedef struct packed {
    logic is_long;
    logic is_short;
  } cls_t;

  typedef struct packed {
    logic              emit;
    logic [CODE_W-1:0] code;
    logic              failed;
  } res_t;

  typedef struct packed {
    logic       aborted;
    logic [1:0] phase;
  } status_t;

  function automatic digit_e digit_of(cls_t c1, cls_t c2, cls_t c3, cls_t c4);
    digit_e d;
    if (c1.is_long && c2.is_short && c3.is_long && c4.is_short) begin
      d = DIG_ZERO;
    end else if (c1.is_short && c2.is_long && c3.is_short && c4.is_long) begin
      d = DIG_ONE;
    end else if (c1.is_short && c2.is_long && c3.is_long && c4.is_short) begin
      d = DIG_TWO;
    end else begin
      d = DIG_BAD;
    end
    return d;
  endfunction

endpackage

FILE: design/trcd_classify.sv
module trcd_classify (
  input  logic [trcd_pkg::LEN_W-1:0] len_i,
  input  trcd_pkg::cfg_t             cfg_i,
  output trcd_pkg::cls_t             cls_o
);

  assign cls_o.is_short = (len_i > cfg_i.short_min) && (len_i < cfg_i.short_max);
  assign cls_o.is_long  = (len_i > cfg_i.long_min) && (len_i < cfg_i.long_max);

endmodule

FILE: design/trcd_frame.sv
module trcd_frame #(
  parameter int unsigned DIGITS = trcd_pkg::DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               frame_start_i,
  input  trcd_pkg::cls_t     cls_i,
  output trcd_pkg::res_t     res_o,
  output trcd_pkg::status_t  status_o
);

  localparam int unsigned CntW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(DIGITS - 1);

  logic [1:0]                    phase_q, phase_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [trcd_pkg::CODE_W-1:0]   acc_q, acc_d;
  logic [trcd_pkg::CODE_W-1:0]   wt_q, wt_d;
  logic                          ab_q, ab_d;
  trcd_pkg::cls_t                held_q [3];
  trcd_pkg::cls_t                held_d [3];

  logic [1:0]                    b_phase;
  logic [CntW-1:0]               b_cnt;
  logic [trcd_pkg::CODE_W-1:0]   b_acc;
  logic [trcd_pkg::CODE_W-1:0]   b_wt;
  logic                          b_ab;
  trcd_pkg::digit_e              dig;

  always_comb begin
    b_phase = frame_start_i ? 2'd0 : phase_q;
    b_cnt   = frame_start_i ? '0 : cnt_q;
    b_acc   = frame_start_i ? '0 : acc_q;
    b_wt    = frame_start_i ? trcd_pkg::CODE_W'(1) : wt_q;
    b_ab    = frame_start_i ? 1'b0 : ab_q;
    dig     = trcd_pkg::digit_of(held_q[0], held_q[1], held_q[2], cls_i);

    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    wt_d    = wt_q;
    ab_d    = ab_q;
    held_d  = held_q;
    res_o   = '0;

    if (step_i) begin
      phase_d = b_phase;
      cnt_d   = b_cnt;
      acc_d   = b_acc;
      wt_d    = b_wt;
      ab_d    = b_ab;
      if (!b_ab) begin
        if (b_phase != 2'd3) begin
          unique case (b_phase)
            2'd0:    held_d[0] = cls_i;
            2'd1:    held_d[1] = cls_i;
            default: held_d[2] = cls_i;
          endcase
          phase_d = b_phase + 2'd1;
        end else begin
          phase_d = 2'd0;
          if (dig == trcd_pkg::DIG_BAD) begin
            ab_d         = 1'b1;
            res_o.emit   = 1'b1;
            res_o.failed = 1'b1;
          end else begin
            unique case (dig)
              trcd_pkg::DIG_ONE: acc_d = b_acc + b_wt;
              trcd_pkg::DIG_TWO: acc_d = b_acc + {b_wt[trcd_pkg::CODE_W-2:0], 1'b0};
              default:           acc_d = b_acc;
            endcase
            wt_d = b_wt + {b_wt[trcd_pkg::CODE_W-2:0], 1'b0};
            if (b_cnt == LastCnt) begin
              ab_d       = 1'b1;
              res_o.emit = 1'b1;
              res_o.code = acc_d;
            end else begin
              cnt_d = b_cnt + CntW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      cnt_q   <= '0;
      acc_q   <= '0;
      wt_q    <= trcd_pkg::CODE_W'(1);
      ab_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      wt_q    <= wt_d;
      ab_q    <= ab_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  assign status_o.aborted = ab_q;
  assign status_o.phase   = phase_q;

endmodule

FILE: design/tristate_remote_code_decoder_unit.sv
// Channel   Direction  Words                   Handshake
// s_axis    in         pulse length, frame flag tvalid/tready
// m_axis    out        code, failed flag        tvalid/tready
// cfg       in         window thresholds        cfg_we_i, no wait
//
// One pulse is taken every cycle while no result stalls; a result passes the pulse
// register and then the result register after the pulse that ends or fails its frame.
// Reset clears the thresholds to their defaults and starts decoding at once.
// A stalled result holds the pulse register, which then drops s_axis_tready.
`include "tristate_remote_code_decoder_unit_defines.svh"

module tristate_remote_code_decoder_unit #(
  parameter int unsigned DIGITS = trcd_pkg::DIGITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] pulse_length
  input  logic                           s_axis_tuser,  // [0] frame_start
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // [19:0] code, zero fill above
  output logic                           m_axis_tuser,  // [0] failed
  input  logic                           cfg_we_i,
  input  logic [trcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [trcd_pkg::CFG_W-1:0]     cfg_data_i
);

  trcd_pkg::cfg_t              cfg_q;
  logic                        in_vld_q;
  logic [trcd_pkg::LEN_W-1:0]  len_q;
  logic                        fs_q;
  logic                        out_vld_q;
  logic [trcd_pkg::CODE_W-1:0] code_q;
  logic                        fail_q;
  logic                        advance;
  trcd_pkg::cls_t              cls;
  trcd_pkg::res_t              res;
  trcd_pkg::status_t           status;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_min <= trcd_pkg::SHORT_MIN_RST;
      cfg_q.short_max <= trcd_pkg::SHORT_MAX_RST;
      cfg_q.long_min  <= trcd_pkg::LONG_MIN_RST;
      cfg_q.long_max  <= trcd_pkg::LONG_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (trcd_pkg::cfg_idx_e'(cfg_idx_i))
        trcd_pkg::REG_SHORT_MIN: cfg_q.short_min <= cfg_data_i;
        trcd_pkg::REG_SHORT_MAX: cfg_q.short_max <= cfg_data_i;
        trcd_pkg::REG_LONG_MIN:  cfg_q.long_min  <= cfg_data_i;
        trcd_pkg::REG_LONG_MAX:  cfg_q.long_max  <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance && res.emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      len_q <= s_axis_tdata;
      fs_q  <= s_axis_tuser;
    end
    if (advance && res.emit) begin
      code_q <= res.code;
      fail_q <= res.failed;
    end
  end

  trcd_classify u_classify (
    .len_i (len_q),
    .cfg_i (cfg_q),
    .cls_o (cls)
  );

  trcd_frame #(
    .DIGITS (DIGITS)
  ) u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .frame_start_i (fs_q),
    .cls_i         (cls),
    .res_o         (res),
    .status_o      (status)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, code_q};
  assign m_axis_tuser  = fail_q;

  `TRCD_ASSERT_RST(a_no_word_in_reset, !rst_ni |-> !m_axis_tvalid, "result valid in reset")
  `TRCD_ASSERT(a_fail_zero_code, m_axis_tvalid && m_axis_tuser |-> code_q == '0,
    "failure result carries a nonzero code")
  `TRCD_ASSERT(a_emit_aborts, advance && res.emit |=> status.aborted,
    "frame not closed after a result")
  `TRCD_ASSERT(a_aborted_phase, status.aborted |-> status.phase == 2'd0,
    "closed frame left a digit half done")

endmodule
